>>> sv/cksb_pkg.sv
// ----------------------------------------------------------------------------
// cksb_pkg: shared types and constants for the color-keyed sprite blitter
// Register indexes, field widths and the decoded configuration struct.
// ----------------------------------------------------------------------------
package cksb_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int CNT_W      = $clog2(MAX_DIM);   // sprite column / row counter
  localparam int DIM_W      = CNT_W + 1;         // holds MAX_DIM itself
  localparam int POS_W      = 11;                // dest_x, dest_y
  localparam int SCR_W      = 12;                // screen and sprite size fields
  localparam int BPP_W      = 3;
  localparam int PIX_W      = 32;
  localparam int OFF_W      = 24;
  localparam int LSTEP_W    = SCR_W + 2;         // screen_width * up to 4
  localparam int X_W        = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SETTLE     = 2;                 // cycles of start-offset pipeline
  localparam int SETTLE_W   = $clog2(SETTLE + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_BYTES_PER_PIX = 3'd6,
    REG_KEY_COLOR     = 3'd7
  } cfg_reg_t;

  // Decoded configuration as seen by the pixel path
  typedef struct packed {
    logic               settled;     // start offset matches the registers
    logic [POS_W-1:0]   dest_x;
    logic [POS_W-1:0]   dest_y;
    logic [DIM_W-1:0]   wid;         // clamped to 1..MAX_DIM
    logic [DIM_W-1:0]   hgt;
    logic [SCR_W-1:0]   scr_w;
    logic [SCR_W-1:0]   scr_h;
    logic [BPP_W-1:0]   bpp;         // clamped to 1..4
    logic [PIX_W-1:0]   mask;
    logic [PIX_W-1:0]   key;
    logic [OFF_W-1:0]   start;       // byte offset of (dest_x, dest_y)
    logic [LSTEP_W-1:0] line_step;   // screen_width * bpp
  } cfg_t;

endpackage

>>> sv/cksb_cfg.sv
// ----------------------------------------------------------------------------
// cksb_cfg: configuration registers and start-offset pipeline
// Holds the register file, clamps sizes and works out the start offset of the
// sprite in two registered steps after every write.
// ----------------------------------------------------------------------------
module cksb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cksb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cksb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cksb_pkg::cfg_t                   cfg
);
  import cksb_pkg::*;

  logic [POS_W-1:0]    dest_x_r, dest_y_r;
  logic [SCR_W-1:0]    spr_w_r, spr_h_r, scr_w_r, scr_h_r;
  logic [BPP_W-1:0]    bpp_r;
  logic [PIX_W-1:0]    key_r;
  logic [OFF_W-1:0]    prod_r, prod_nxt;
  logic [OFF_W-1:0]    start_r, start_nxt;
  logic [LSTEP_W-1:0]  lstep_r, lstep_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [BPP_W-1:0]    bpp_eff;
  logic [PIX_W-1:0]    mask;
  logic [DIM_W-1:0]    wid, hgt;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SCR_W-1:0] d);
    logic [DIM_W:0] dx;
    dx = (DIM_W + 1)'(d);
    if (d == '0)
      return DIM_W'(1);
    else if (dx > (DIM_W + 1)'(MAX_DIM))
      return DIM_W'(MAX_DIM);
    else
      return dx[DIM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r <= '0;
      dest_y_r <= '0;
      spr_w_r  <= SCR_W'(1);
      spr_h_r  <= SCR_W'(1);
      scr_w_r  <= SCR_W'(1024);
      scr_h_r  <= SCR_W'(768);
      bpp_r    <= BPP_W'(4);
      key_r    <= '0;
      settle_r <= SETTLE_W'(SETTLE);
    end else begin
      settle_r <= settle_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEST_X:        dest_x_r <= cfg_data[POS_W-1:0];
          REG_DEST_Y:        dest_y_r <= cfg_data[POS_W-1:0];
          REG_SPRITE_WIDTH:  spr_w_r  <= cfg_data[SCR_W-1:0];
          REG_SPRITE_HEIGHT: spr_h_r  <= cfg_data[SCR_W-1:0];
          REG_SCREEN_WIDTH:  scr_w_r  <= cfg_data[SCR_W-1:0];
          REG_SCREEN_HEIGHT: scr_h_r  <= cfg_data[SCR_W-1:0];
          REG_BYTES_PER_PIX: bpp_r    <= cfg_data[BPP_W-1:0];
          REG_KEY_COLOR:     key_r    <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // offset pipeline runs freely; settle count tells when it has caught up
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    start_r <= start_nxt;
    lstep_r <= lstep_nxt;
  end

  always_comb begin
    if (cfg_we)
      settle_nxt = SETTLE_W'(SETTLE);
    else if (settle_r != '0)
      settle_nxt = settle_r - SETTLE_W'(1);
    else
      settle_nxt = settle_r;
  end

  always_comb begin
    if (bpp_r == '0)
      bpp_eff = BPP_W'(1);
    else if (bpp_r > BPP_W'(4))
      bpp_eff = BPP_W'(4);
    else
      bpp_eff = bpp_r;

    prod_nxt = OFF_W'(dest_y_r) * OFF_W'(scr_w_r) + OFF_W'(dest_x_r);

    case (bpp_eff)
      BPP_W'(1): begin
        mask      = 32'h0000_00ff;
        start_nxt = prod_r;
        lstep_nxt = LSTEP_W'(scr_w_r);
      end
      BPP_W'(2): begin
        mask      = 32'h0000_ffff;
        start_nxt = prod_r << 1;
        lstep_nxt = LSTEP_W'(scr_w_r) << 1;
      end
      BPP_W'(3): begin
        mask      = 32'h00ff_ffff;
        start_nxt = prod_r + (prod_r << 1);
        lstep_nxt = LSTEP_W'(scr_w_r) + (LSTEP_W'(scr_w_r) << 1);
      end
      default: begin
        mask      = 32'hffff_ffff;
        start_nxt = prod_r << 2;
        lstep_nxt = LSTEP_W'(scr_w_r) << 2;
      end
    endcase

    wid = clamp_dim(spr_w_r);
    hgt = clamp_dim(spr_h_r);
  end

  assign cfg.settled   = (settle_r == '0);
  assign cfg.dest_x    = dest_x_r;
  assign cfg.dest_y    = dest_y_r;
  assign cfg.wid       = wid;
  assign cfg.hgt       = hgt;
  assign cfg.scr_w     = scr_w_r;
  assign cfg.scr_h     = scr_h_r;
  assign cfg.bpp       = bpp_eff;
  assign cfg.mask      = mask;
  assign cfg.key       = key_r;
  assign cfg.start     = start_r;
  assign cfg.line_step = lstep_r;

endmodule

>>> sv/color_key_sprite_blitter_core.sv
// ----------------------------------------------------------------------------
// color_key_sprite_blitter_core: color-keyed sprite pixel walker
// Walks sprite pixels in row-major order, masks and key-tests each one, keeps
// running frame-buffer byte offsets and clips pixels that fall off screen.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_we             cfg_index, cfg_data
//   in       in         in_valid/in_ready  in_pixel_value, in_first_pixel
//   out      out        out_valid/out_ready write_strobe, off_screen,
//                                           byte_offset, write_color, sprite_done
//
// One item per cycle while in_ready is high; each result is captured in the output
// register in the cycle after its item is accepted. After reset and after every
// register write in_ready stays low while the start offset (one multiply, then
// a shift-add by bytes per pixel) is recomputed. A stalled result holds the
// output register and in_ready drops in the same cycle.
// ----------------------------------------------------------------------------
module color_key_sprite_blitter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cksb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cksb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cksb_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                             in_first_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_write_strobe,
  output logic                             out_off_screen,
  output logic [cksb_pkg::OFF_W-1:0]       out_byte_offset,
  output logic [cksb_pkg::PIX_W-1:0]       out_write_color,
  output logic                             out_sprite_done
);
  import cksb_pkg::*;

  cfg_t cfg;

  cksb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic               accept;
  logic               restart_r, restart_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [OFF_W-1:0]   pix_off_r, pix_off_nxt, line_off_r, line_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               strobe_r, off_r, done_r;
  logic [OFF_W-1:0]   offset_r;
  logic [PIX_W-1:0]   color_r;

  // values for the item at the input
  logic               restart;
  logic [CNT_W-1:0]   col, row;
  logic [OFF_W-1:0]   pix_off, line_off;
  logic [PIX_W-1:0]   color;
  logic [X_W-1:0]     x, y;
  logic               off, strobe, last_col, done;
  logic [DIM_W-1:0]   col_inc, row_inc;

  assign in_ready = cfg.settled && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    restart  = in_first_pixel || restart_r;
    col      = restart ? '0 : col_r;
    row      = restart ? '0 : row_r;
    pix_off  = restart ? cfg.start : pix_off_r;
    line_off = restart ? cfg.start : line_off_r;

    color  = in_pixel_value & cfg.mask;
    x      = X_W'(cfg.dest_x) + X_W'(col);
    y      = X_W'(cfg.dest_y) + X_W'(row);
    off    = (x >= X_W'(cfg.scr_w)) || (y >= X_W'(cfg.scr_h));
    strobe = !off && (color != cfg.key);

    col_inc  = DIM_W'(col) + DIM_W'(1);
    row_inc  = DIM_W'(row) + DIM_W'(1);
    last_col = (col_inc >= cfg.wid);
    done     = last_col && (row_inc >= cfg.hgt);

    restart_nxt  = restart_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pix_off_nxt  = pix_off_r;
    line_off_nxt = line_off_r;
    if (cfg_we) begin
      restart_nxt = 1'b1;
    end else if (accept) begin
      // sprite end reloads through the restart flag on the next item
      restart_nxt = done;
      if (last_col) begin
        col_nxt      = '0;
        row_nxt      = row_inc[CNT_W-1:0];
        line_off_nxt = line_off + OFF_W'(cfg.line_step);
        pix_off_nxt  = line_off + OFF_W'(cfg.line_step);
      end else begin
        col_nxt     = col_inc[CNT_W-1:0];
        row_nxt     = row;
        line_off_nxt = line_off;
        pix_off_nxt = pix_off + OFF_W'(cfg.bpp);
      end
    end

    if (accept)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r   <= 1'b1;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      restart_r   <= restart_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_off_r  <= pix_off_nxt;
    line_off_r <= line_off_nxt;
    if (accept) begin
      strobe_r <= strobe;
      off_r    <= off;
      offset_r <= off ? '0 : pix_off;
      color_r  <= color;
      done_r   <= done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_strobe = strobe_r;
  assign out_off_screen   = off_r;
  assign out_byte_offset  = offset_r;
  assign out_write_color  = color_r;
  assign out_sprite_done  = done_r;

endmodule

>>> sv/cksb_checker.sv
// ----------------------------------------------------------------------------
// cksb_sva: port-level checks for the sprite blitter
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module cksb_sva (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_write_strobe,
  input logic                             out_off_screen,
  input logic [cksb_pkg::OFF_W-1:0]       out_byte_offset
);
  import cksb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_offset)
      && $stable(out_write_strobe))
    else $error("result changed while stalled");

  // clipped pixels are never written
  a_clip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_write_strobe && out_off_screen))
    else $error("strobe on an off-screen pixel");

  a_clip_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_off_screen |-> out_byte_offset == '0)
    else $error("nonzero offset on an off-screen pixel");

  // no item taken while the start offset is being recomputed
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready ##1 !in_ready)
    else $error("item accepted before start offset settled");

endmodule

bind color_key_sprite_blitter_core cksb_sva u_cksb_sva (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_write_strobe (out_write_strobe),
  .out_off_screen   (out_off_screen),
  .out_byte_offset  (out_byte_offset)
);

>>> tb/sv/cksb_checker.sv
// ----------------------------------------------------------------------------
// cksb_checker: pixel walk predictor and result scoreboard
// Watches the register port and both pixel channels of the blitter core.
// Keeps its own copy of the registers and the sprite walk, predicts the
// write result for every accepted pixel and compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cksb_checker
  import cksb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic                  in_first_pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_write_strobe,
  input  logic                  out_off_screen,
  input  logic [OFF_W-1:0]      out_byte_offset,
  input  logic [PIX_W-1:0]      out_write_color,
  input  logic                  out_sprite_done,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic             strobe;
    logic             off;
    logic [OFF_W-1:0] offset;
    logic [PIX_W-1:0] color;
    logic             done;
  } blit_result_t;

  // register copy
  logic [POS_W-1:0] dst_x, dst_y;
  logic [SCR_W-1:0] spr_w, spr_h, scr_w, scr_h;
  logic [BPP_W-1:0] bpp_raw;
  logic [PIX_W-1:0] key;

  // sprite walk
  logic [CNT_W-1:0] col, row;
  logic [OFF_W-1:0] pix_off, line_off;

  blit_result_t predicted_writes[$];
  int           mismatches = 0;

  assign fail_count  = mismatches;
  assign outstanding = predicted_writes.size();

  function automatic int unsigned eff_bytes();
    if (bpp_raw == 0) return 1;
    if (bpp_raw > 4) return 4;
    return bpp_raw;
  endfunction

  function automatic int unsigned clamp_dim(input logic [SCR_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  task automatic rewind_walk();
    int unsigned start;
    start = (int'(dst_y) * int'(scr_w) + int'(dst_x)) * eff_bytes();
    col      = '0;
    row      = '0;
    pix_off  = start[OFF_W-1:0];
    line_off = start[OFF_W-1:0];
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_DEST_X:        dst_x   = val[POS_W-1:0];
      REG_DEST_Y:        dst_y   = val[POS_W-1:0];
      REG_SPRITE_WIDTH:  spr_w   = val[SCR_W-1:0];
      REG_SPRITE_HEIGHT: spr_h   = val[SCR_W-1:0];
      REG_SCREEN_WIDTH:  scr_w   = val[SCR_W-1:0];
      REG_SCREEN_HEIGHT: scr_h   = val[SCR_W-1:0];
      REG_BYTES_PER_PIX: bpp_raw = val[BPP_W-1:0];
      REG_KEY_COLOR:     key     = val[PIX_W-1:0];
      default: ;
    endcase
    rewind_walk();
  endtask

  task automatic walk_pixel(input logic [PIX_W-1:0] pix, input logic restart,
                            output blit_result_t res);
    int unsigned      nbytes, wid, hgt, x, y;
    logic [PIX_W-1:0] keep;
    logic             last_col;
    nbytes = eff_bytes();
    wid    = clamp_dim(spr_w);
    hgt    = clamp_dim(spr_h);
    if (restart) rewind_walk();
    keep       = (nbytes >= 4) ? '1 : (32'h1 << (8 * nbytes)) - 32'h1;
    res.color  = pix & keep;
    x          = dst_x + col;
    y          = dst_y + row;
    res.off    = (x >= scr_w) || (y >= scr_h);
    // key is compared at full width, so key bits above the pixel never match
    res.strobe = !res.off && (res.color != key);
    res.offset = res.off ? '0 : pix_off;
    last_col   = (col + 1 >= wid);
    res.done   = last_col && (row + 1 >= hgt);
    if (res.done) begin
      rewind_walk();
    end else if (last_col) begin
      col      = '0;
      row      = row + 1'b1;
      line_off = line_off + scr_w * nbytes;
      pix_off  = line_off;
    end else begin
      col     = col + 1'b1;
      pix_off = pix_off + nbytes;
    end
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    blit_result_t want, got;
    if (!rst_n) begin
      dst_x   = '0;
      dst_y   = '0;
      spr_w   = 1;
      spr_h   = 1;
      scr_w   = 1024;
      scr_h   = 768;
      bpp_raw = 4;
      key     = '0;
      rewind_walk();
      predicted_writes.delete();
    end else begin
      // retire first: the result leaving now belongs to an older item
      if (out_valid && out_ready) begin
        if (predicted_writes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual offset %h color %h",
                   $time, out_byte_offset, out_write_color);
          mismatches++;
        end else begin
          want = predicted_writes.pop_front();
          if (out_write_strobe !== want.strobe)
            report("write_strobe", want.strobe, out_write_strobe);
          if (out_off_screen !== want.off)
            report("off_screen", want.off, out_off_screen);
          if (out_byte_offset !== want.offset)
            report("byte_offset", want.offset, out_byte_offset);
          if (out_write_color !== want.color)
            report("write_color", want.color, out_write_color);
          if (out_sprite_done !== want.done)
            report("sprite_done", want.done, out_sprite_done);
        end
      end
      if (cfg_we) load_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        walk_pixel(in_pixel_value, in_first_pixel, got);
        predicted_writes.push_back(got);
      end
    end
  end

endmodule

>>> tb/sv/tb_color_key_sprite_blitter_core.sv
// ----------------------------------------------------------------------------
// tb_color_key_sprite_blitter_core: stimulus and verdict for the blitter core
// Directed sprites at the register extremes and clipping corners, a sprite
// wider than the dimension limit, then random sprites under random register
// settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_color_key_sprite_blitter_core;
  import cksb_pkg::*;

  localparam int LIMIT   = 500000;
  localparam int RX_HOLD = 120;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_value = '0;
  logic                  in_first_pixel = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  out_write_strobe;
  logic                  out_off_screen;
  logic [OFF_W-1:0]      out_byte_offset;
  logic [PIX_W-1:0]      out_write_color;
  logic                  out_sprite_done;

  int fail_count;
  int outstanding;
  int cycles = 0;

  bit idle_on     = 1'b1;
  bit rx_hold_req = 1'b0;

  // last programmed register values, used to shape sprites
  logic [SCR_W-1:0] sh_w, sh_h;
  logic [BPP_W-1:0] sh_bpp;
  logic [PIX_W-1:0] sh_key;

  always #4 clk = ~clk;

  color_key_sprite_blitter_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_value   (in_pixel_value),
    .in_first_pixel   (in_first_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_strobe (out_write_strobe),
    .out_off_screen   (out_off_screen),
    .out_byte_offset  (out_byte_offset),
    .out_write_color  (out_write_color),
    .out_sprite_done  (out_sprite_done)
  );

  cksb_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_value   (in_pixel_value),
    .in_first_pixel   (in_first_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_strobe (out_write_strobe),
    .out_off_screen   (out_off_screen),
    .out_byte_offset  (out_byte_offset),
    .out_write_color  (out_write_color),
    .out_sprite_done  (out_sprite_done),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random ready bursts, plus one long hold on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic restart);
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_first_pixel <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // sender stops and waits until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] dx, dy, sw, sh, scw, sch, bpp,
                              key);
    logic [CFG_DATA_W-1:0] v [1 << CFG_IDX_W];
    cfg_reg_t              r;
    v[REG_DEST_X]        = dx;
    v[REG_DEST_Y]        = dy;
    v[REG_SPRITE_WIDTH]  = sw;
    v[REG_SPRITE_HEIGHT] = sh;
    v[REG_SCREEN_WIDTH]  = scw;
    v[REG_SCREEN_HEIGHT] = sch;
    v[REG_BYTES_PER_PIX] = bpp;
    v[REG_KEY_COLOR]     = key;
    sh_w   = sw[SCR_W-1:0];
    sh_h   = sh[SCR_W-1:0];
    sh_bpp = bpp[BPP_W-1:0];
    sh_key = key;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // whole sprites with random content; noise adds restarts mid-sprite
  task automatic run_phase(input int n_items, input bit noise);
    int unsigned      wid, hgt, area, nbytes, pos;
    logic [PIX_W-1:0] keep, pix;
    logic             restart;
    wid    = (sh_w == 0) ? 1 : (sh_w > MAX_DIM) ? MAX_DIM : sh_w;
    hgt    = (sh_h == 0) ? 1 : (sh_h > MAX_DIM) ? MAX_DIM : sh_h;
    area   = wid * hgt;
    nbytes = (sh_bpp == 0) ? 1 : (sh_bpp > 4) ? 4 : sh_bpp;
    keep   = (nbytes >= 4) ? '1 : (32'h1 << (8 * nbytes)) - 32'h1;
    pos    = 0;
    repeat (n_items) begin
      case ($urandom_range(0, 7))
        0:       pix = ($urandom() & ~keep) | (sh_key & keep);
        1:       pix = sh_key;
        2:       pix = '1;
        3:       pix = '0;
        default: pix = $urandom();
      endcase
      if (pos == 0) restart = $urandom_range(0, 1);
      else          restart = noise && ($urandom_range(0, 31) == 0);
      if (restart) pos = 0;
      send_pixel(pix, restart);
      pos++;
      if (pos == area) pos = 0;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dx, dy, sw, sh, scw, sch, bpp;
    int                    n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-pixel sprite, key of zero
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h8000_0001, 1'b1);
    drain();

    // sprite hanging over the bottom right corner, one byte per pixel
    program_regs(8, 3, 4, 3, 10, 5, 1, 32'h0000_00AB);
    for (int i = 0; i < 12; i++)
      send_pixel((i % 3 == 0) ? {24'($urandom_range(0, 32'hFF_FFFF)), 8'hAB} : $urandom(),
                 i == 7);
    drain();

    // last screen pixel, zero sprite size, bytes per pixel above range
    program_regs(2047, 2047, 0, 0, 2048, 2048, 7, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    drain();

    // empty screen, zero bytes per pixel, key with bits above the pixel
    program_regs(0, 0, 3, 2, 0, 0, 0, 32'hFF00_00AB);
    for (int i = 0; i < 6; i++) send_pixel(32'h0000_00AB, 1'b0);
    drain();

    program_regs(1, 0, 2, 2, 2, 1, 2, 32'h0000_BEEF);
    for (int i = 0; i < 4; i++) send_pixel(32'h1234_BEEF, 1'b0);
    drain();

    // width above the limit: the first row runs on as one long line
    program_regs(0, 0, 4095, 1, 2048, 768, 3, 0);
    run_phase(64, 1'b0);
    drain();

    for (int p = 0; p < 24; p++) begin
      case ($urandom_range(0, 9))
        0:       sw = 0;
        1:       sw = $urandom_range(2048, 4095);
        default: sw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       sh = 0;
        1:       sh = $urandom_range(2048, 4095);
        default: sh = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       scw = 0;
        1, 2:    scw = $urandom_range(1, 16);
        3:       scw = $urandom_range(0, 4095);
        default: scw = $urandom_range(1, 2048);
      endcase
      case ($urandom_range(0, 9))
        0:       sch = 0;
        1, 2:    sch = $urandom_range(1, 16);
        3:       sch = $urandom_range(0, 4095);
        default: sch = $urandom_range(1, 2048);
      endcase
      // mostly near the screen edge so clipping shows up
      dx  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, (scw + 4) % 2048);
      dy  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, (sch + 4) % 2048);
      bpp = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 7);
      program_regs(dx, dy, sw, sh, scw, sch, bpp, $urandom());
      if (p >= 20) idle_on = 1'b0;
      n = $urandom_range(30, 70);
      if (p == 5) rx_hold_req = 1'b1;
      if (p == 9) begin
        run_phase(n / 2, 1'b1);
        drain();
        run_phase(n - n / 2, 1'b1);
      end else begin
        run_phase(n, 1'b1);
      end
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> color_key_sprite_blitter_core.f
sv/cksb_pkg.sv
sv/cksb_cfg.sv
sv/color_key_sprite_blitter_core.sv
sv/cksb_checker.sv
tb/sv/cksb_checker.sv
tb/sv/tb_color_key_sprite_blitter_core.sv
